[rtl/min_max_stack_unit_defines.svh]
// Assertion macros used by the min/max stack RTL.
`ifndef MIN_MAX_STACK_UNIT_DEFINES_SVH
`define MIN_MAX_STACK_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MMS_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define MMS_ASSERT(lbl, prop, msg)
`define MMS_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

[rtl/mms_pkg.sv]
// Types and constants shared by the min/max stack modules.
package mms_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_PUSH = 2'd0;
    localparam cmd_t CMD_POP  = 2'd1;

    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_FULL  = 2'd1;
    localparam err_t ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] low;
        logic signed [DATA_W-1:0] high;
    } entry_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] smallest;
        logic signed [DATA_W-1:0] largest;
        logic                     is_empty;
        err_t                     error;
    } result_t;

endpackage

[rtl/mms_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mms_stack.sv]
// Stack storage and per-item update: top entry in registers, lower entries in RAM.
module mms_stack import mms_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  cmd_t                     command,
    input  logic signed [DATA_W-1:0] value,
    output result_t                  result
);

    logic [COUNT_W-1:0] count_reg, count_next;
    entry_t             top_reg, top_next;
    entry_t             byp_reg, byp_next;
    logic               byp_valid_reg, byp_valid_next;

    entry_t             rd_data;
    entry_t             second;
    logic               ram_we;
    logic [COUNT_W-1:0] wr_cnt;
    logic [COUNT_W-1:0] rd_cnt;
    logic               full;
    logic               empty;
    logic signed [DATA_W-1:0] push_low;
    logic signed [DATA_W-1:0] push_high;
    logic signed [DATA_W-1:0] popped;
    err_t               err;
    logic               empty_after;

    assign full   = (count_reg == COUNT_W'(STACK_DEPTH));
    assign empty  = (count_reg == '0);
    assign second = byp_valid_reg ? byp_reg : rd_data;
    assign wr_cnt = count_reg - COUNT_W'(1);
    assign rd_cnt = count_next - COUNT_W'(2);

    assign push_low  = (!empty && (top_reg.low < value)) ? top_reg.low : value;
    assign push_high = (!empty && (value < top_reg.high)) ? top_reg.high : value;

    always_comb begin
        count_next     = count_reg;
        top_next       = top_reg;
        byp_next       = byp_reg;
        byp_valid_next = byp_valid_reg;
        ram_we         = 1'b0;
        popped         = '0;
        err            = ERR_NONE;
        if (fire) begin
            unique case (command)
                CMD_PUSH: begin
                    if (full) begin
                        err = ERR_FULL;
                    end else begin
                        top_next.value = value;
                        top_next.low   = push_low;
                        top_next.high  = push_high;
                        count_next     = count_reg + COUNT_W'(1);
                        byp_next       = top_reg;
                        byp_valid_next = 1'b1;
                        ram_we         = !empty;
                    end
                end
                CMD_POP: begin
                    if (empty) begin
                        err = ERR_EMPTY;
                    end else begin
                        popped         = top_reg.value;
                        top_next       = second;
                        count_next     = count_reg - COUNT_W'(1);
                        byp_valid_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign empty_after = (count_next == '0);

    always_comb begin
        result.popped_value = popped;
        result.count        = count_next;
        result.smallest     = empty_after ? '0 : top_next.low;
        result.largest      = empty_after ? '0 : top_next.high;
        result.is_empty     = empty_after;
        result.error        = err;
    end

    mms_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_cnt[ADDR_W-1:0]),
        .wdata(top_reg),
        .raddr(rd_cnt[ADDR_W-1:0]),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        byp_reg <= byp_next;
    end

endmodule

[rtl/min_max_stack_unit.sv]
// The result of an item is registered and presented in the cycle after its transfer is accepted.
// Throughput: one item per cycle while m_ready accepts each result; the top entry lives in
// registers, the one below is prefetched from the RAM read port: pushes and pops add no stall.
// Reset empties the stack and drops the result valid flag; entry storage is not cleared
// and needs no clearing pass.
module min_max_stack_unit import mms_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic signed [DATA_W-1:0]  s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DATA_W-1:0]  m_popped_value,
    output logic [COUNT_W-1:0]        m_count,
    output logic signed [DATA_W-1:0]  m_smallest,
    output logic signed [DATA_W-1:0]  m_largest,
    output logic                      m_is_empty,
    output logic [1:0]                m_error
);

`include "min_max_stack_unit_defines.svh"

    logic    fire;
    result_t result;
    result_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    mms_stack u_stack (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (fire),
        .command(cmd_t'(s_command)),
        .value  (s_value),
        .result (result)
    );

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (fire) begin
            out_next     = result;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = out_reg.popped_value;
    assign m_count        = out_reg.count;
    assign m_smallest     = out_reg.smallest;
    assign m_largest      = out_reg.largest;
    assign m_is_empty     = out_reg.is_empty;
    assign m_error        = out_reg.error;

    `MMS_ASSERT(a_count_range, (m_valid |-> (m_count <= STACK_DEPTH)), "count above depth")
    `MMS_ASSERT(a_empty_flag, (m_valid |-> (m_is_empty == (m_count == '0))), "empty flag wrong")
    `MMS_ASSERT(a_full_err,
                ((m_valid && (m_error == ERR_FULL)) |-> (m_count == STACK_DEPTH)),
                "full error without full stack")
    `MMS_ASSERT(a_min_le_max,
                ((m_valid && !m_is_empty) |-> (m_smallest <= m_largest)),
                "minimum above maximum")
    `MMS_ASSERT_ALL(a_reset_idle, (!aresetn |=> !m_valid), "result valid after reset")

endmodule
